/* rtl/core/jmsp_pkg.sv */
// Package: phase codes, segment kinds, marker codes and request types for the marker parser.
`default_nettype none
package jmsp_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] MarkerSoi  = 8'hD8;
  localparam logic [7:0] MarkerEoi  = 8'hD9;
  localparam logic [7:0] MarkerApp0 = 8'hE0;
  localparam logic [7:0] MarkerDqt  = 8'hDB;
  localparam logic [7:0] MarkerSof0 = 8'hC0;
  localparam logic [7:0] MarkerDht  = 8'hC4;
  localparam logic [7:0] MarkerSos  = 8'hDA;
  localparam logic [7:0] LowNibMask  = 8'h0F;
  localparam logic [7:0] HighNibMask = 8'hF0;
  localparam logic [17:0] QuantEntries = 18'd64;
  localparam logic [17:0] HuffCounts   = 18'd16;

  typedef enum logic [2:0] {
    KIND_SOI   = 3'd0,
    KIND_APP0  = 3'd1,
    KIND_DQT   = 3'd2,
    KIND_SOF   = 3'd3,
    KIND_DHT   = 3'd4,
    KIND_SOS   = 3'd5,
    KIND_EOI   = 3'd6,
    KIND_OTHER = 3'd7
  } kind_t;

  typedef enum logic [5:0] {
    PH_M1, PH_M2, PH_LH, PH_LL,
    PH_AFORM, PH_AMAJ, PH_AMIN, PH_ADEN, PH_AXH, PH_AXL, PH_AYH, PH_AYL,
    PH_AXS, PH_AYS, PH_ATHUMB,
    PH_QNO, PH_QTAB,
    PH_FPREC, PH_FHH, PH_FHL, PH_FWH, PH_FWL, PH_FNO, PH_FCOMP,
    PH_HNO, PH_HCNT, PH_HVAL,
    PH_SNO, PH_SCOMP, PH_SREM,
    PH_SKIP, PH_DONE
  } phase_t;

  // One result field set.
  typedef struct packed {
    logic [2:0]  segment_kind;
    logic [3:0]  field_number;
    logic [15:0] field_value;
    logic [17:0] element_index;
  } result_t;

  // Work request from the front to the back: up to two results per byte.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } request_t;

  function automatic kind_t kind_of(input logic [7:0] t);
    kind_t k;
    unique case (t)
      MarkerApp0: k = KIND_APP0;
      MarkerDqt:  k = KIND_DQT;
      MarkerSof0: k = KIND_SOF;
      MarkerDht:  k = KIND_DHT;
      MarkerSos:  k = KIND_SOS;
      default:    k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/jmsp_if.sv */
// Interfaces: valid/ready byte channel and result channel.
`default_nettype none
interface jmsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface jmsp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  segment_kind;
  logic [3:0]  field_number;
  logic [15:0] field_value;
  logic [17:0] element_index;
  logic        last_of_run;
  modport source (output valid, output segment_kind, output field_number,
                  output field_value, output element_index, output last_of_run,
                  input ready);
  modport sink   (input valid, input segment_kind, input field_number,
                  input field_value, input element_index, input last_of_run,
                  output ready);
endinterface
`default_nettype wire

/* rtl/core/jpeg_marker_segment_parser.sv */
// Top level of the JPEG marker segment parser.
// Takes one byte per cycle while the request queue is not full; a parse state machine
// turns each byte into up to two result items, queued in a 4-entry request queue and
// sent one per cycle while the output is ready. A byte that gives two results holds the
// output for both of them, so input keeps one byte per cycle only when each byte gives at
// most one result. Results appear, at the earliest, in the cycle after their byte is taken.
`default_nettype none
module jpeg_marker_segment_parser #(
  parameter int unsigned QDepth = jmsp_pkg::QueueDepth
) (
  input wire logic clk,
  input wire logic rst_n,
  jmsp_byte_if.sink     in_ch,
  jmsp_result_if.source out_ch
);
  import jmsp_pkg::*;

  logic     req_valid, q_full, q_ne, q_pop;
  request_t req, head;
  result_t  res;

  jmsp_front u_front (
    .clk, .rst_n,
    .byte_valid(in_ch.valid), .byte_data(in_ch.byte_in), .byte_ready(in_ch.ready),
    .req_valid, .req, .q_full
  );

  jmsp_queue #(.Depth(QDepth)) u_queue (
    .clk, .rst_n, .push(req_valid), .push_data(req), .full(q_full),
    .not_empty(q_ne), .head, .pop(q_pop)
  );

  jmsp_back u_back (
    .clk, .rst_n, .q_not_empty(q_ne), .q_head(head), .q_pop,
    .out_valid(out_ch.valid), .out_res(res), .out_last(out_ch.last_of_run),
    .out_ready(out_ch.ready)
  );

  assign out_ch.segment_kind  = res.segment_kind;
  assign out_ch.field_number  = res.field_number;
  assign out_ch.field_value   = res.field_value;
  assign out_ch.element_index = res.element_index;
endmodule
`default_nettype wire

/* rtl/core/jmsp_front.sv */
// Front end: parse FSM, one byte per cycle unless q_full, up to one request each.
`default_nettype none
module jmsp_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_valid,
  input  wire logic [7:0]        byte_data,
  output      logic              byte_ready,
  output      logic              req_valid,
  output      jmsp_pkg::request_t req,
  input  wire logic              q_full
);
  import jmsp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  seg_type_r, seg_type_nxt;
  logic [17:0] count_r, count_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [17:0] total_r, total_nxt;
  logic [7:0]  thumb_w_r, thumb_w_nxt;
  logic        finished_r, finished_nxt;
  // Thumbnail byte total for the APP0 segment: 3*w*h.
  logic [17:0] thumb_total;
  logic [17:0] cnt_inc;
  logic [15:0] word;
  logic [1:0]  comp_mod_r, comp_mod_nxt;
  logic [17:0] comp_idx_r, comp_idx_nxt;
  logic        fire;
  kind_t       k;

  assign byte_ready = !q_full;
  assign fire       = byte_valid && byte_ready;
  assign word       = {held_r, byte_data};
  assign cnt_inc    = count_r + 18'd1;
  assign k          = kind_of(seg_type_r);

  // Form 3*w*h from an 8x8 product plus a shift-add.
  always_comb begin
    logic [15:0] wh;
    wh          = 16'(thumb_w_r) * 16'(byte_data);
    thumb_total = {2'b0, wh} + {1'b0, wh, 1'b0};
  end

  // Compute next parse state.
  always_comb begin
    phase_nxt    = phase_r;
    seg_type_nxt = seg_type_r;
    count_nxt    = count_r;
    held_nxt     = held_r;
    total_nxt    = total_r;
    thumb_w_nxt  = thumb_w_r;
    finished_nxt = finished_r;
    comp_mod_nxt = comp_mod_r;
    comp_idx_nxt = comp_idx_r;
    if (!finished_r) begin
      unique case (phase_r)
        PH_M1: phase_nxt = PH_M2;
        PH_M2: begin
          seg_type_nxt = byte_data;
          if (byte_data == MarkerSoi) begin
            phase_nxt = PH_M1; count_nxt = '0;
          end else if (byte_data == MarkerEoi) begin
            finished_nxt = 1'b1; phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_LH;
          end
        end
        PH_LH: begin held_nxt = byte_data; phase_nxt = PH_LL; end
        PH_LL: begin
          count_nxt = '0;
          unique case (k)
            KIND_APP0: phase_nxt = PH_AFORM;
            KIND_DQT:  phase_nxt = PH_QNO;
            KIND_SOF:  phase_nxt = PH_FPREC;
            KIND_DHT:  phase_nxt = PH_HNO;
            KIND_SOS:  phase_nxt = PH_SNO;
            default: begin
              total_nxt = (word >= 16'd2) ? {2'b0, word - 16'd2} : '0;
              phase_nxt = (word > 16'd2) ? PH_SKIP : PH_M1;
            end
          endcase
        end
        PH_AFORM: begin
          count_nxt = cnt_inc;
          if (cnt_inc >= 18'd5) begin count_nxt = '0; phase_nxt = PH_AMAJ; end
        end
        PH_AMAJ: phase_nxt = PH_AMIN;
        PH_AMIN: phase_nxt = PH_ADEN;
        PH_ADEN: phase_nxt = PH_AXH;
        PH_AXH:  begin held_nxt = byte_data; phase_nxt = PH_AXL; end
        PH_AXL:  phase_nxt = PH_AYH;
        PH_AYH:  begin held_nxt = byte_data; phase_nxt = PH_AYL; end
        PH_AYL:  phase_nxt = PH_AXS;
        PH_AXS:  begin thumb_w_nxt = byte_data; phase_nxt = PH_AYS; end
        PH_AYS: begin
          count_nxt = '0; total_nxt = thumb_total;
          phase_nxt = (thumb_total == '0) ? PH_M1 : PH_ATHUMB;
        end
        PH_QNO: begin
          count_nxt = '0;
          total_nxt = ((byte_data & HighNibMask) != 8'd0) ? (QuantEntries << 1)
                                                           : QuantEntries;
          phase_nxt = PH_QTAB;
        end
        PH_FPREC: phase_nxt = PH_FHH;
        PH_FHH:   begin held_nxt = byte_data; phase_nxt = PH_FHL; end
        PH_FHL:   phase_nxt = PH_FWH;
        PH_FWH:   begin held_nxt = byte_data; phase_nxt = PH_FWL; end
        PH_FWL:   phase_nxt = PH_FNO;
        PH_FNO: begin
          count_nxt = '0; comp_mod_nxt = '0; comp_idx_nxt = '0;
          total_nxt = {10'd0, byte_data} + {9'd0, byte_data, 1'b0};
          phase_nxt = (byte_data == 8'd0) ? PH_M1 : PH_FCOMP;
        end
        PH_FCOMP: begin
          count_nxt = cnt_inc;
          if (comp_mod_r == 2'd2) begin
            comp_mod_nxt = '0; comp_idx_nxt = comp_idx_r + 18'd1;
          end else begin
            comp_mod_nxt = comp_mod_r + 2'd1;
          end
          if (cnt_inc >= total_r) begin phase_nxt = PH_M1; count_nxt = '0; end
        end
        PH_HNO: begin count_nxt = '0; total_nxt = '0; phase_nxt = PH_HCNT; end
        PH_HCNT: begin
          total_nxt = total_r + {10'd0, byte_data};
          count_nxt = cnt_inc;
          if (cnt_inc >= HuffCounts) begin
            count_nxt = '0;
            phase_nxt = (total_nxt == '0) ? PH_M1 : PH_HVAL;
          end
        end
        PH_SNO: begin
          count_nxt = '0;
          total_nxt = {9'd0, byte_data, 1'b0};
          phase_nxt = (byte_data == 8'd0) ? PH_SREM : PH_SCOMP;
        end
        PH_SCOMP: begin
          count_nxt = cnt_inc;
          if (cnt_inc >= total_r) begin count_nxt = '0; phase_nxt = PH_SREM; end
        end
        PH_SREM: begin
          count_nxt = cnt_inc;
          if (cnt_inc >= 18'd3) begin count_nxt = '0; phase_nxt = PH_M1; end
        end
        PH_ATHUMB, PH_QTAB, PH_HVAL, PH_SKIP: begin
          count_nxt = cnt_inc;
          if (cnt_inc >= total_r) begin count_nxt = '0; phase_nxt = PH_M1; end
        end
        default: ;
      endcase
    end
  end

  // Build the request for this byte.
  always_comb begin
    logic [15:0] bval, lo, hi;
    bval = {8'd0, byte_data};
    lo   = {8'd0, byte_data & LowNibMask};
    hi   = {12'd0, byte_data[7:4]};
    req_valid = 1'b0;
    req.two   = 1'b0;
    req.first  = '{segment_kind: k, field_number: 4'd0, field_value: bval,
                   element_index: '0};
    req.second = '{segment_kind: k, field_number: 4'd0, field_value: hi,
                   element_index: '0};
    if (!finished_r) begin
      unique case (phase_r)
        PH_M2: begin
          if (byte_data == MarkerSoi) begin
            req_valid = 1'b1; req.first.segment_kind = KIND_SOI;
          end else if (byte_data == MarkerEoi) begin
            req_valid = 1'b1; req.first.segment_kind = KIND_EOI;
          end
        end
        PH_LL: begin
          req_valid = (k != KIND_OTHER); req.first.field_value = word;
        end
        PH_AFORM: begin
          req_valid = 1'b1; req.first.field_number = 4'd1;
          req.first.element_index = count_r;
        end
        PH_AMAJ: begin req_valid = 1'b1; req.first.field_number = 4'd2; end
        PH_AMIN: begin req_valid = 1'b1; req.first.field_number = 4'd3; end
        PH_ADEN: begin req_valid = 1'b1; req.first.field_number = 4'd4; end
        PH_AXL: begin
          req_valid = 1'b1; req.first.field_number = 4'd5; req.first.field_value = word;
        end
        PH_AYL: begin
          req_valid = 1'b1; req.first.field_number = 4'd6; req.first.field_value = word;
        end
        PH_AXS: begin req_valid = 1'b1; req.first.field_number = 4'd7; end
        PH_AYS: begin req_valid = 1'b1; req.first.field_number = 4'd8; end
        PH_ATHUMB: begin
          req_valid = 1'b1; req.first.field_number = 4'd9;
          req.first.element_index = count_r;
        end
        PH_QNO, PH_HNO: begin
          req_valid = 1'b1; req.two = 1'b1;
          req.first.field_number = 4'd1; req.first.field_value = lo;
          req.second.field_number = 4'd2;
        end
        PH_QTAB, PH_HVAL: begin
          req_valid = 1'b1;
          req.first.field_number = (phase_r == PH_QTAB) ? 4'd3 : 4'd4;
          req.first.element_index = count_r;
        end
        PH_FPREC: begin req_valid = 1'b1; req.first.field_number = 4'd1; end
        PH_FHL: begin
          req_valid = 1'b1; req.first.field_number = 4'd2; req.first.field_value = word;
        end
        PH_FWL: begin
          req_valid = 1'b1; req.first.field_number = 4'd3; req.first.field_value = word;
        end
        PH_FNO: begin req_valid = 1'b1; req.first.field_number = 4'd4; end
        PH_FCOMP: begin
          req_valid = 1'b1;
          req.first.field_number = 4'd5 + {2'd0, comp_mod_r};
          req.first.element_index = comp_idx_r;
        end
        PH_HCNT: begin
          req_valid = 1'b1; req.first.field_number = 4'd3;
          req.first.element_index = count_r;
        end
        PH_SNO: begin req_valid = 1'b1; req.first.field_number = 4'd1; end
        PH_SCOMP: begin
          req_valid = 1'b1;
          req.first.element_index  = {1'b0, count_r[17:1]};
          req.second.element_index = {1'b0, count_r[17:1]};
          if (!count_r[0]) begin
            req.first.field_number = 4'd2;
          end else begin
            req.two = 1'b1;
            req.first.field_number = 4'd3; req.first.field_value = lo;
            req.second.field_number = 4'd4;
          end
        end
        PH_SREM: begin
          req_valid = 1'b1; req.first.field_number = 4'd5;
          req.first.element_index = count_r;
        end
        default: ;
      endcase
    end
    req_valid = req_valid && fire;
  end

  // Advance state on each accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_M1; seg_type_r <= '0; count_r <= '0; held_r <= '0;
      total_r <= '0; thumb_w_r <= '0; finished_r <= 1'b0;
      comp_mod_r <= '0; comp_idx_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt; seg_type_r <= seg_type_nxt; count_r <= count_nxt;
      held_r <= held_nxt; total_r <= total_nxt; thumb_w_r <= thumb_w_nxt;
      finished_r <= finished_nxt; comp_mod_r <= comp_mod_nxt;
      comp_idx_r <= comp_idx_nxt;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/jmsp_queue.sv */
// Request queue between front and back.
`default_nettype none
module jmsp_queue #(
  parameter int unsigned Depth = jmsp_pkg::QueueDepth
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire jmsp_pkg::request_t push_data,
  output      logic               full,
  output      logic               not_empty,
  output      jmsp_pkg::request_t head,
  input  wire logic               pop
);
  import jmsp_pkg::*;
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  request_t        mem_r [Depth];
  logic [Aw-1:0]   wp_r, rp_r;
  logic [Aw:0]     cnt_r;

  assign full      = (cnt_r == (Aw+1)'(Depth));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rp_r];

  // Store the pushed request.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  // Move pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == Aw'(Depth - 1)) ? '0 : wp_r + Aw'(1);
      if (pop)  rp_r <= (rp_r == Aw'(Depth - 1)) ? '0 : rp_r + Aw'(1);
      cnt_r <= cnt_r + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end
endmodule
`default_nettype wire

/* rtl/core/jmsp_back.sv */
// Back end: unpacks each request into one or two result items.
`default_nettype none
module jmsp_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_not_empty,
  input  wire jmsp_pkg::request_t q_head,
  output      logic               q_pop,
  output      logic               out_valid,
  output      jmsp_pkg::result_t  out_res,
  output      logic               out_last,
  input  wire logic               out_ready
);
  import jmsp_pkg::*;

  logic sel_r;
  logic take;

  assign out_valid = q_not_empty;
  assign out_res   = sel_r ? q_head.second : q_head.first;
  assign out_last  = sel_r || !q_head.two;
  assign take      = out_valid && out_ready;
  assign q_pop     = take && out_last;

  // Step to the second result of a two-result request.
  always_ff @(posedge clk) begin
    if (!rst_n) sel_r <= 1'b0;
    else if (take) sel_r <= !out_last;
  end
endmodule
`default_nettype wire

/* rtl/core/jmsp_checker.sv */
// Port checker for the marker parser, bound to the top level.
`default_nettype none
module jmsp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_kind,
  input wire logic [3:0] out_field,
  input wire logic       out_last
);
  // Held result stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_field))
    else $error("result changed while stalled");
  // Kind 7 never reaches the output.
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind != 3'd7) else $error("bad kind");
  // Field number stays within range.
  a_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_field <= 4'd9) else $error("bad field");
  // A non-last result is the low nibble of a split byte.
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_field == 4'd1 || out_field == 4'd3)
    else $error("unexpected first of pair");
endmodule

bind jpeg_marker_segment_parser jmsp_checker u_chk (
  .clk, .rst_n, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_kind(out_ch.segment_kind), .out_field(out_ch.field_number),
  .out_last(out_ch.last_of_run)
);
`default_nettype wire

/* tb/sv/tb_jmsp_scoreboard.sv */
// Scoreboard for the marker parser: parse-state predictor and store of expected field results.
`timescale 1ns / 1ps
class jmsp_field_scoreboard;
  jmsp_pkg::phase_t phase;
  logic [7:0]  seg_type;
  logic [17:0] byte_cnt;
  logic [7:0]  high_byte;
  logic [17:0] rep_total;
  logic [7:0]  thumb_w;
  logic        done;
  jmsp_pkg::result_t pending_fields[$];
  logic              pending_last[$];
  int errors;
  int checked;
  logic [7:0] step_fields;

  function void reset_state();
    phase = jmsp_pkg::PH_M1;
    seg_type = '0;
    byte_cnt = '0;
    high_byte = '0;
    rep_total = '0;
    thumb_w = '0;
    done = 1'b0;
    errors = 0;
    checked = 0;
    pending_fields.delete();
    pending_last.delete();
  endfunction

  function void push(logic [2:0] k, logic [3:0] f, logic [15:0] v, logic [17:0] e);
    jmsp_pkg::result_t r;
    r.segment_kind = k;
    r.field_number = f;
    r.field_value = v;
    r.element_index = e;
    pending_fields.push_back(r);
    pending_last.push_back(1'b0);
    step_fields++;
  endfunction

  function void back_to_marker();
    phase = jmsp_pkg::PH_M1;
    byte_cnt = '0;
  endfunction

  function void start_run(jmsp_pkg::phase_t ph, logic [17:0] total);
    byte_cnt = '0;
    rep_total = total;
    if (total == 0) back_to_marker();
    else phase = ph;
  endfunction

  // Advance the parse state by one byte and queue the fields it yields.
  function void note_byte(logic [7:0] b);
    logic [15:0] word;
    jmsp_pkg::kind_t k;
    word = {high_byte, b};
    step_fields = 0;
    if (done) return;
    case (phase)
      jmsp_pkg::PH_M1: phase = jmsp_pkg::PH_M2;
      jmsp_pkg::PH_M2: begin
        seg_type = b;
        if (b == jmsp_pkg::MarkerSoi) begin
          push(jmsp_pkg::KIND_SOI, 0, b, 0);
          back_to_marker();
        end else if (b == jmsp_pkg::MarkerEoi) begin
          push(jmsp_pkg::KIND_EOI, 0, b, 0);
          done = 1'b1;
          phase = jmsp_pkg::PH_DONE;
        end else phase = jmsp_pkg::PH_LH;
      end
      jmsp_pkg::PH_LH: begin
        high_byte = b;
        phase = jmsp_pkg::PH_LL;
      end
      jmsp_pkg::PH_LL: begin
        k = jmsp_pkg::kind_of(seg_type);
        byte_cnt = '0;
        if (k == jmsp_pkg::KIND_OTHER) begin
          start_run(jmsp_pkg::PH_SKIP, word >= 2 ? 18'(word - 16'd2) : 18'd0);
        end else begin
          push(k, 0, word, 0);
          case (k)
            jmsp_pkg::KIND_APP0: phase = jmsp_pkg::PH_AFORM;
            jmsp_pkg::KIND_DQT:  phase = jmsp_pkg::PH_QNO;
            jmsp_pkg::KIND_SOF:  phase = jmsp_pkg::PH_FPREC;
            jmsp_pkg::KIND_DHT:  phase = jmsp_pkg::PH_HNO;
            default:             phase = jmsp_pkg::PH_SNO;
          endcase
        end
      end
      jmsp_pkg::PH_AFORM: begin
        push(jmsp_pkg::KIND_APP0, 1, b, byte_cnt);
        byte_cnt++;
        if (byte_cnt >= 5) begin
          byte_cnt = '0;
          phase = jmsp_pkg::PH_AMAJ;
        end
      end
      jmsp_pkg::PH_AMAJ: begin
        push(jmsp_pkg::KIND_APP0, 2, b, 0);
        phase = jmsp_pkg::PH_AMIN;
      end
      jmsp_pkg::PH_AMIN: begin
        push(jmsp_pkg::KIND_APP0, 3, b, 0);
        phase = jmsp_pkg::PH_ADEN;
      end
      jmsp_pkg::PH_ADEN: begin
        push(jmsp_pkg::KIND_APP0, 4, b, 0);
        phase = jmsp_pkg::PH_AXH;
      end
      jmsp_pkg::PH_AXH: begin
        high_byte = b;
        phase = jmsp_pkg::PH_AXL;
      end
      jmsp_pkg::PH_AXL: begin
        push(jmsp_pkg::KIND_APP0, 5, word, 0);
        phase = jmsp_pkg::PH_AYH;
      end
      jmsp_pkg::PH_AYH: begin
        high_byte = b;
        phase = jmsp_pkg::PH_AYL;
      end
      jmsp_pkg::PH_AYL: begin
        push(jmsp_pkg::KIND_APP0, 6, word, 0);
        phase = jmsp_pkg::PH_AXS;
      end
      jmsp_pkg::PH_AXS: begin
        push(jmsp_pkg::KIND_APP0, 7, b, 0);
        thumb_w = b;
        phase = jmsp_pkg::PH_AYS;
      end
      jmsp_pkg::PH_AYS: begin
        push(jmsp_pkg::KIND_APP0, 8, b, 0);
        start_run(jmsp_pkg::PH_ATHUMB, 18'(3 * int'(thumb_w) * int'(b)));
      end
      jmsp_pkg::PH_ATHUMB, jmsp_pkg::PH_QTAB, jmsp_pkg::PH_HVAL: begin
        if (phase == jmsp_pkg::PH_ATHUMB) push(jmsp_pkg::KIND_APP0, 9, b, byte_cnt);
        else if (phase == jmsp_pkg::PH_QTAB) push(jmsp_pkg::KIND_DQT, 3, b, byte_cnt);
        else push(jmsp_pkg::KIND_DHT, 4, b, byte_cnt);
        byte_cnt++;
        if (byte_cnt >= rep_total) back_to_marker();
      end
      jmsp_pkg::PH_QNO: begin
        push(jmsp_pkg::KIND_DQT, 1, b & jmsp_pkg::LowNibMask, 0);
        push(jmsp_pkg::KIND_DQT, 2, (b & jmsp_pkg::HighNibMask) >> 4, 0);
        start_run(jmsp_pkg::PH_QTAB, (b & jmsp_pkg::HighNibMask) != 0 ?
                  2 * jmsp_pkg::QuantEntries : jmsp_pkg::QuantEntries);
      end
      jmsp_pkg::PH_FPREC: begin
        push(jmsp_pkg::KIND_SOF, 1, b, 0);
        phase = jmsp_pkg::PH_FHH;
      end
      jmsp_pkg::PH_FHH: begin
        high_byte = b;
        phase = jmsp_pkg::PH_FHL;
      end
      jmsp_pkg::PH_FHL: begin
        push(jmsp_pkg::KIND_SOF, 2, word, 0);
        phase = jmsp_pkg::PH_FWH;
      end
      jmsp_pkg::PH_FWH: begin
        high_byte = b;
        phase = jmsp_pkg::PH_FWL;
      end
      jmsp_pkg::PH_FWL: begin
        push(jmsp_pkg::KIND_SOF, 3, word, 0);
        phase = jmsp_pkg::PH_FNO;
      end
      jmsp_pkg::PH_FNO: begin
        push(jmsp_pkg::KIND_SOF, 4, b, 0);
        start_run(jmsp_pkg::PH_FCOMP, 18'(3 * int'(b)));
      end
      jmsp_pkg::PH_FCOMP: begin
        push(jmsp_pkg::KIND_SOF, 4'(5 + byte_cnt % 3), b, byte_cnt / 3);
        byte_cnt++;
        if (byte_cnt >= rep_total) back_to_marker();
      end
      jmsp_pkg::PH_HNO: begin
        push(jmsp_pkg::KIND_DHT, 1, b & jmsp_pkg::LowNibMask, 0);
        push(jmsp_pkg::KIND_DHT, 2, (b & jmsp_pkg::HighNibMask) >> 4, 0);
        byte_cnt = '0;
        rep_total = '0;
        phase = jmsp_pkg::PH_HCNT;
      end
      jmsp_pkg::PH_HCNT: begin
        push(jmsp_pkg::KIND_DHT, 3, b, byte_cnt);
        rep_total += b;
        byte_cnt++;
        if (byte_cnt >= jmsp_pkg::HuffCounts) start_run(jmsp_pkg::PH_HVAL, rep_total);
      end
      jmsp_pkg::PH_SNO: begin
        push(jmsp_pkg::KIND_SOS, 1, b, 0);
        byte_cnt = '0;
        rep_total = 18'(2 * int'(b));
        phase = (b == 0) ? jmsp_pkg::PH_SREM : jmsp_pkg::PH_SCOMP;
      end
      jmsp_pkg::PH_SCOMP: begin
        if (!byte_cnt[0]) begin
          push(jmsp_pkg::KIND_SOS, 2, b, byte_cnt >> 1);
        end else begin
          push(jmsp_pkg::KIND_SOS, 3, b & jmsp_pkg::LowNibMask, byte_cnt >> 1);
          push(jmsp_pkg::KIND_SOS, 4, (b & jmsp_pkg::HighNibMask) >> 4, byte_cnt >> 1);
        end
        byte_cnt++;
        if (byte_cnt >= rep_total) begin
          byte_cnt = '0;
          phase = jmsp_pkg::PH_SREM;
        end
      end
      jmsp_pkg::PH_SREM: begin
        push(jmsp_pkg::KIND_SOS, 5, b, byte_cnt);
        byte_cnt++;
        if (byte_cnt >= 3) back_to_marker();
      end
      jmsp_pkg::PH_SKIP: begin
        byte_cnt++;
        if (byte_cnt >= rep_total) back_to_marker();
      end
      default: ;
    endcase
    if (step_fields > 0) pending_last[pending_last.size() - 1] = 1'b1;
  endfunction

  // Compare one delivered field result with the oldest pending one.
  function void check_field(jmsp_pkg::result_t got, logic got_last);
    jmsp_pkg::result_t exp_r;
    logic exp_last;
    checked++;
    if (pending_fields.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result kind=%0d field=%0d value=%0h elem=%0d",
                 got.segment_kind, got.field_number, got.field_value, got.element_index);
      return;
    end
    exp_r = pending_fields.pop_front();
    exp_last = pending_last.pop_front();
    if (got !== exp_r || got_last !== exp_last) begin
      errors++;
      if (errors <= 10)
        $display("result %0d: exp k=%0d f=%0d v=%0h e=%0d l=%0b got k=%0d f=%0d v=%0h e=%0d l=%0b",
                 checked, exp_r.segment_kind, exp_r.field_number, exp_r.field_value,
                 exp_r.element_index, exp_last, got.segment_kind, got.field_number,
                 got.field_value, got.element_index, got_last);
    end
  endfunction
endclass

/* tb/sv/tb.sv */
// Top of the marker parser testbench: clock, reset, byte stream driver and result monitor.
`timescale 1ns / 1ps
module tb;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  jmsp_byte_if   in_if();
  jmsp_result_if out_if();
  jmsp_field_scoreboard fields_sb;
  logic [7:0] file_bytes[$];
  int sent_bytes;
  int idle_cycles;
  bit stim_done;
  localparam int WatchdogLimit = 2000;

  jpeg_marker_segment_parser dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source)
  );

  always #2 clk = ~clk;

  initial begin
    in_if.valid = 1'b0;
    in_if.byte_in = '0;
    out_if.ready = 1'b0;
    fields_sb = new();
    fields_sb.reset_state();
  end

  // Append helpers for building the byte stream.
  task automatic add(logic [7:0] b);
    file_bytes.push_back(b);
  endtask

  task automatic add_marker(logic [7:0] t);
    add($urandom_range(0, 255));
    add(t);
  endtask

  task automatic add_word(logic [15:0] w);
    add(w[15:8]);
    add(w[7:0]);
  endtask

  task automatic add_random_bytes(int n);
    repeat (n) add($urandom_range(0, 255));
  endtask

  // Build one segment of the kind chosen by pick, with random content; pick 7 gives a too-short length word.
  task automatic add_segment(int pick);
    int n;
    int sum;
    logic [7:0] b;
    case (pick)
      0: add_marker(jmsp_pkg::MarkerSoi);
      1: begin
        add_marker(jmsp_pkg::MarkerApp0);
        add_word($urandom);
        add_random_bytes(5 + 3 + 4);
        b = $urandom_range(0, 3);
        add(b);
        n = (b == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
        add(n);
        add_random_bytes(3 * b * n);
      end
      2: begin
        add_marker(jmsp_pkg::MarkerDqt);
        add_word($urandom);
        b = $urandom_range(0, 255);
        if ($urandom_range(0, 1)) b[7:4] = 4'h0;
        add(b);
        add_random_bytes(b[7:4] != 0 ? 128 : 64);
      end
      3: begin
        add_marker(jmsp_pkg::MarkerSof0);
        add_word($urandom);
        add_random_bytes(5);
        n = $urandom_range(0, 4);
        add(n);
        add_random_bytes(3 * n);
      end
      4: begin
        add_marker(jmsp_pkg::MarkerDht);
        add_word($urandom);
        add($urandom_range(0, 255));
        sum = 0;
        repeat (16) begin
          b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
          sum += b;
          add(b);
        end
        add_random_bytes(sum);
      end
      5: begin
        add_marker(jmsp_pkg::MarkerSos);
        add_word($urandom);
        n = $urandom_range(0, 4);
        add(n);
        add_random_bytes(2 * n + 3);
      end
      default: begin
        do b = $urandom_range(0, 255);
        while (b == jmsp_pkg::MarkerEoi || b == jmsp_pkg::MarkerSoi ||
               jmsp_pkg::kind_of(b) != jmsp_pkg::KIND_OTHER);
        add_marker(b);
        n = $urandom_range(0, 12);
        add_word((pick == 7) ? 16'($urandom_range(0, 1)) : 16'(n + 2));
        if (pick != 7) add_random_bytes(n);
      end
    endcase
  endtask

  // Send one byte request, with a random hold-off before it.
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (sent_bytes % 400 < 60) gap = 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.byte_in <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    fields_sb.note_byte(b);
    sent_bytes++;
    @(negedge clk);
  endtask

  // Result side: random stall before each result, then check on accept.
  initial begin : result_sink
    int stall;
    jmsp_pkg::result_t got;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if ((fields_sb.checked / 300) % 2 == 1) stall = 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      got.segment_kind = out_if.segment_kind;
      got.field_number = out_if.field_number;
      got.field_value = out_if.field_value;
      got.element_index = out_if.element_index;
      fields_sb.check_field(got, out_if.last_of_run);
    end
  end

  // Watchdog: count cycles with no request moving on either side.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && !stim_done && idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired after %0d bytes", sent_bytes);
      $display("jpeg_marker_segment_parser: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int limit;
    idle_cycles = 0;
    sent_bytes = 0;
    stim_done = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: SOI, extreme APP0, SOS with no components, unknown with short length, SOF with
    // none, DHT empty, then one DQT, SOS and DHT segment each, random stream, EOI.
    add(8'hFF); add(jmsp_pkg::MarkerSoi);
    add(8'h00); add(jmsp_pkg::MarkerApp0); add_word(16'hFFFF);
    add(8'h00); add(8'hFF); add(8'h55); add(8'hAA); add(8'h0F);
    add(8'h01); add(8'h02); add(8'hFF); add_word(16'hFFFF); add_word(16'h0000);
    add(8'h00); add(8'hFF);
    add(8'hFF); add(jmsp_pkg::MarkerSos); add_word(16'h0000); add(8'h00);
    add(8'hFF); add(8'h00); add(8'h80);
    add(8'h00); add(8'h01); add_word(16'h0001);
    add(8'hFF); add(jmsp_pkg::MarkerSof0); add_word(16'h8000);
    add_random_bytes(5); add(8'h00);
    add(8'hFF); add(jmsp_pkg::MarkerDht); add_word(16'h1234); add(8'hF0);
    repeat (16) add(8'h00);
    add_segment(2); add_segment(5); add_segment(4);
    limit = 1600;
    while (file_bytes.size() < limit) add_segment($urandom_range(0, 7));
    // End marker, then a noise tail: bytes after the end marker must give nothing.
    add(8'hFF); add(jmsp_pkg::MarkerEoi);
    add_random_bytes(20);

    foreach (file_bytes[i]) send_byte(file_bytes[i]);
    in_if.valid <= 1'b0;
    while (fields_sb.pending_fields.size() != 0) @(posedge clk);
    stim_done = 1;
    repeat (50) @(posedge clk);
    $display("sent %0d bytes of random segments, %0d field results checked, %0d errors",
             sent_bytes, fields_sb.checked, fields_sb.errors);
    if (fields_sb.errors == 0 && fields_sb.pending_fields.size() == 0)
      $display("jpeg_marker_segment_parser: match");
    else
      $display("jpeg_marker_segment_parser: mismatch");
    $finish;
  end
endmodule
